// ===== rtl/core/ctet_pkg.sv =====
// ----------------------------------------------------------------------------
// ctet_pkg
// Shared types and codes for the countdown event timer table.
// ----------------------------------------------------------------------------
package ctet_pkg;

  localparam int TimeW = 32;
  localparam int TagW  = 8;
  localparam int WordW = 64;

  localparam logic ACTION_ADD  = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  localparam logic STATUS_FIRED = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  localparam logic [TagW-1:0] TAG_NULL = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [TimeW-1:0] rem;
    logic [TagW-1:0]  tag;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } entry_t;

endpackage

// ===== rtl/core/ctet_ram.sv =====
// ----------------------------------------------------------------------------
// ctet_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ctet_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/countdown_event_timer_table_unit.sv =====
// ----------------------------------------------------------------------------
// countdown_event_timer_table_unit
// Table of pending timed events in insertion order; a tick fires, drops and
// ages the entries and compacts the survivors in place.
//
//   channel  direction  handshake            beat
//   command  in         start_i / busy_o     action, delay, tag, words, elapsed
//   result   out        valid_o (one cycle)  status, tag, out words, last
//
// An add leaves busy_o low; a full table gives its result on the cycle after.
// A tick on a filled table does one RAM read per entry, waits out the read
// latency, then closes the scan in ST_DONE; on an empty table it does nothing
// and busy_o stays low. The single RAM port pair paces the scan.
// A fired entry is held until the next one fires or the scan closes, so its
// beat trails the entry and the final one can be last.
// Reset empties the table; no clearing pass is needed.
// The receiver cannot stall: every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module countdown_event_timer_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          action_i,
  input  logic [ctet_pkg::TimeW-1:0]    delay_i,
  input  logic [ctet_pkg::TagW-1:0]     handler_tag_i,
  input  logic [ctet_pkg::WordW-1:0]    word_a_i,
  input  logic [ctet_pkg::WordW-1:0]    word_b_i,
  input  logic [ctet_pkg::WordW-1:0]    word_c_i,
  input  logic [ctet_pkg::WordW-1:0]    word_d_i,
  input  logic [ctet_pkg::TimeW-1:0]    elapsed_i,
  output logic                          valid_o,
  output logic                          status_o,
  output logic [ctet_pkg::TagW-1:0]     fired_tag_o,
  output logic [ctet_pkg::WordW-1:0]    out_a_o,
  output logic [ctet_pkg::WordW-1:0]    out_b_o,
  output logic [ctet_pkg::WordW-1:0]    out_c_o,
  output logic [ctet_pkg::WordW-1:0]    out_d_o,
  output logic                          last_o
);

  import ctet_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rd_q, rd_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [TimeW-1:0] el_q, el_d;
  logic pend_vld_q, pend_vld_d;
  entry_t pend_q, pend_d;

  logic out_vld_q, out_vld_d;
  logic out_status_q, out_status_d;
  logic out_last_q, out_last_d;
  entry_t out_q, out_d;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  entry_t ram_wdata;
  entry_t ram_rdata;
  entry_t new_ent;

  ctet_ram #(
    .Width($bits(entry_t)),
    .Depth(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign new_ent = '{rem: delay_i, tag: handler_tag_i, a: word_a_i,
                     b: word_b_i, c: word_c_i, d: word_d_i};

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    el_d         = el_q;
    pend_vld_d   = pend_vld_q;
    pend_d       = pend_q;
    out_vld_d    = 1'b0;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = wr_q[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = rd_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        ram_raddr = '0;
        if (start_i) begin
          if (action_i == ACTION_ADD) begin
            if (cnt_q >= DepthC) begin
              out_vld_d    = 1'b1;
              out_status_d = STATUS_FULL;
              out_last_d   = 1'b1;
              out_d        = '0;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_q[AW-1:0];
              ram_wdata = new_ent;
              cnt_d     = cnt_q + OneC;
            end
          end else if (cnt_q != '0) begin
            state_d    = ST_SCAN;
            rd_d       = OneC;
            wr_d       = '0;
            el_d       = elapsed_i;
            pend_vld_d = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        // advance the read pointer while entries remain
        if (rd_q < cnt_q) begin
          rd_d = rd_q + OneC;
        end else begin
          state_d = ST_DONE;
        end
        if (ram_rdata.tag != TAG_NULL) begin
          if (ram_rdata.rem <= el_q) begin
            if (pend_vld_q) begin
              out_vld_d    = 1'b1;
              out_status_d = STATUS_FIRED;
              out_last_d   = 1'b0;
              out_d        = pend_q;
            end
            pend_vld_d = 1'b1;
            pend_d     = ram_rdata;
          end else begin
            ram_we        = 1'b1;
            ram_wdata.rem = ram_rdata.rem - el_q;
            wr_d          = wr_q + OneC;
          end
        end
      end
      ST_DONE: begin
        cnt_d   = wr_q;
        state_d = ST_IDLE;
        if (pend_vld_q) begin
          out_vld_d    = 1'b1;
          out_status_d = STATUS_FIRED;
          out_last_d   = 1'b1;
          out_d        = pend_q;
          pend_vld_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    el_q         <= el_d;
    pend_q       <= pend_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
    out_q        <= out_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign valid_o     = out_vld_q;
  assign status_o    = out_status_q;
  assign fired_tag_o = out_q.tag;
  assign out_a_o     = out_q.a;
  assign out_b_o     = out_q.b;
  assign out_c_o     = out_q.c;
  assign out_d_o     = out_q.d;
  assign last_o      = out_last_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("entry count beyond table depth");

  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (wr_q < rd_q))
    else $error("compaction write overtook read");

  a_full_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == STATUS_FULL) |-> last_o)
    else $error("table full beat not marked last");

  a_fire_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == STATUS_FIRED) |->
      ($past(state_q) == ST_SCAN || $past(state_q) == ST_DONE))
    else $error("fired beat outside a tick");
`endif

endmodule

// ===== tb/countdown_event_timer_table_unit_test.sv =====
// ----------------------------------------------------------------------------
// countdown_event_timer_table_unit_test
// Drives add and tick commands into the timer table with random gaps. A
// scoreboard keeps its own copy of the event table and predicts every fired
// event and every table-full rejection. Each result beat is then checked field
// by field, in order, against those predictions.
// ----------------------------------------------------------------------------
module countdown_event_timer_table_unit_test;
  import ctet_pkg::*;

  localparam int TableDepth = 16;
  localparam int CmdCount   = 350;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic             action;
    logic [TimeW-1:0] delay;
    logic [TagW-1:0]  tag;
    logic [WordW-1:0] a, b, c, d;
    logic [TimeW-1:0] elapsed;
  } command_t;

  typedef struct packed {
    logic             status;
    logic [TagW-1:0]  tag;
    logic [WordW-1:0] a, b, c, d;
    logic             last;
  } fire_t;

  class event_table_scoreboard;
    entry_t      slots[TableDepth];
    int unsigned fill;
    fire_t       expected_fires[$];
    int unsigned errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void queue_fire(fire_t f);
      expected_fires = {expected_fires, f};
    endfunction

    function void note_command(command_t cmd);
      fire_t       f;
      fire_t       held;
      bit          have_held;
      int unsigned wr;
      int unsigned rd;
      if (cmd.action == ACTION_ADD) begin
        if (fill >= TableDepth) begin
          f        = '0;
          f.status = STATUS_FULL;
          f.last   = 1'b1;
          queue_fire(f);
        end else begin
          slots[fill].rem = cmd.delay;
          slots[fill].tag = cmd.tag;
          slots[fill].a   = cmd.a;
          slots[fill].b   = cmd.b;
          slots[fill].c   = cmd.c;
          slots[fill].d   = cmd.d;
          fill++;
        end
        return;
      end
      have_held = 1'b0;
      held      = '0;
      wr        = 0;
      for (rd = 0; rd < fill; rd++) begin
        if (slots[rd].tag == TAG_NULL) continue;
        if (slots[rd].rem <= cmd.elapsed) begin
          if (have_held) queue_fire(held);
          held.status = STATUS_FIRED;
          held.tag    = slots[rd].tag;
          held.a      = slots[rd].a;
          held.b      = slots[rd].b;
          held.c      = slots[rd].c;
          held.d      = slots[rd].d;
          held.last   = 1'b0;
          have_held   = 1'b1;
          continue;
        end
        slots[wr]     = slots[rd];
        slots[wr].rem = slots[rd].rem - cmd.elapsed;
        wr++;
      end
      fill = wr;
      if (have_held) begin
        held.last = 1'b1;
        queue_fire(held);
      end
    endfunction

    function void compare_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(fire_t got);
      fire_t want;
      if (expected_fires.size() == 0) begin
        $error("result beat with nothing expected: status %0h tag %0h", got.status, got.tag);
        errors++;
        return;
      end
      want = expected_fires.pop_front();
      compare_field("status", WordW'(want.status), WordW'(got.status));
      compare_field("fired_tag", WordW'(want.tag), WordW'(got.tag));
      compare_field("out_a", want.a, got.a);
      compare_field("out_b", want.b, got.b);
      compare_field("out_c", want.c, got.c);
      compare_field("out_d", want.d, got.d);
      compare_field("last", WordW'(want.last), WordW'(got.last));
    endfunction

    function int unsigned outstanding();
      return expected_fires.size();
    endfunction
  endclass

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             start_i       = 1'b0;
  logic             action_i      = ACTION_ADD;
  logic [TimeW-1:0] delay_i       = '0;
  logic [TagW-1:0]  handler_tag_i = '0;
  logic [WordW-1:0] word_a_i      = '0;
  logic [WordW-1:0] word_b_i      = '0;
  logic [WordW-1:0] word_c_i      = '0;
  logic [WordW-1:0] word_d_i      = '0;
  logic [TimeW-1:0] elapsed_i     = '0;
  logic             busy_o;
  logic             valid_o;
  logic             status_o;
  logic [TagW-1:0]  fired_tag_o;
  logic [WordW-1:0] out_a_o;
  logic [WordW-1:0] out_b_o;
  logic [WordW-1:0] out_c_o;
  logic [WordW-1:0] out_d_o;
  logic             last_o;

  event_table_scoreboard scoreboard;
  int unsigned           cycle_count = 0;
  int unsigned           sent        = 0;
  bit                    steady      = 1'b0;

  countdown_event_timer_table_unit #(
    .TABLE_DEPTH(TableDepth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .delay_i      (delay_i),
    .handler_tag_i(handler_tag_i),
    .word_a_i     (word_a_i),
    .word_b_i     (word_b_i),
    .word_c_i     (word_c_i),
    .word_d_i     (word_d_i),
    .elapsed_i    (elapsed_i),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .fired_tag_o  (fired_tag_o),
    .out_a_o      (out_a_o),
    .out_b_o      (out_b_o),
    .out_c_o      (out_c_o),
    .out_d_o      (out_d_o),
    .last_o       (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        scoreboard.note_command(command_t'{action: action_i, delay: delay_i,
                                           tag: handler_tag_i, a: word_a_i, b: word_b_i,
                                           c: word_c_i, d: word_d_i, elapsed: elapsed_i});
      end
      if (valid_o) begin
        scoreboard.check_result(fire_t'{status: status_o, tag: fired_tag_o, a: out_a_o,
                                        b: out_b_o, c: out_c_o, d: out_d_o, last: last_o});
      end
    end
  end

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [TimeW-1:0] rand_time(int unsigned span);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(0, span);
    endcase
  endfunction

  function automatic command_t add_cmd(logic [TimeW-1:0] delay, logic [TagW-1:0] tag,
                                       logic [WordW-1:0] a, logic [WordW-1:0] b,
                                       logic [WordW-1:0] c, logic [WordW-1:0] d);
    return command_t'{action: ACTION_ADD, delay: delay, tag: tag, a: a, b: b, c: c, d: d,
                      elapsed: $urandom};
  endfunction

  function automatic command_t tick_cmd(logic [TimeW-1:0] elapsed);
    return command_t'{action: ACTION_TICK, delay: $urandom, tag: TagW'($urandom),
                      a: rand_word(), b: rand_word(), c: rand_word(), d: rand_word(),
                      elapsed: elapsed};
  endfunction

  function automatic command_t rand_add(bit wild);
    logic [TagW-1:0] tag;
    tag = ($urandom_range(0, 9) == 0) ? TAG_NULL : TagW'($urandom_range(0, 255));
    return add_cmd(wild ? TimeW'($urandom) : rand_time(200), tag, rand_word(), rand_word(),
                   rand_word(), rand_word());
  endfunction

  task automatic send_command(input command_t cmd);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    action_i      <= cmd.action;
    delay_i       <= cmd.delay;
    handler_tag_i <= cmd.tag;
    word_a_i      <= cmd.a;
    word_b_i      <= cmd.b;
    word_c_i      <= cmd.c;
    word_d_i      <= cmd.d;
    elapsed_i     <= cmd.elapsed;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic wait_for_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (scoreboard.outstanding() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int i;
    scoreboard = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(tick_cmd('0));
    send_command(add_cmd('0, 8'hFF, '1, '1, '1, '1));
    send_command(add_cmd(32'd5, TAG_NULL, '0, '0, '0, '0));
    send_command(add_cmd('1, 8'h01, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                         '0, '1));
    send_command(tick_cmd('0));
    send_command(tick_cmd('1));
    for (i = 1; i <= TableDepth; i++) begin
      send_command(add_cmd(TimeW'(i), TagW'(i), rand_word(), rand_word(), rand_word(),
                           rand_word()));
    end
    send_command(add_cmd(32'd3, 8'h80, '1, '1, '1, '1));
    send_command(tick_cmd(32'd8));
    send_command(tick_cmd('1));
    wait_for_results();

    while (sent < CmdCount) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_command($urandom_range(0, 1) ? tick_cmd($urandom) : rand_add(1'b1));
        end
      end else begin
        repeat ($urandom_range(0, 20)) send_command(rand_add(1'b0));
        repeat ($urandom_range(1, 3)) send_command(tick_cmd(rand_time(80)));
      end
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (TableDepth + 4) @(posedge clk_i);
    if (scoreboard.errors == 0 && scoreboard.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== countdown_event_timer_table_unit.f =====
rtl/core/ctet_pkg.sv
rtl/core/ctet_ram.sv
rtl/core/countdown_event_timer_table_unit.sv
tb/countdown_event_timer_table_unit_test.sv
